/* rtl/ndem_pkg.sv */
// Shared constants, types and window evaluation for the neighbour difference edge map.
package ndem_pkg;

  localparam int MAX_WIDTH  = 2048;
  localparam int MAX_HEIGHT = 4095;
  localparam int PIX_W      = 8;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT + 1);
  localparam int CFG_W      = 12;
  localparam int LINE_DW    = 2 * PIX_W;

  localparam logic [1:0] CFG_IMAGE_WIDTH    = 2'd0;
  localparam logic [1:0] CFG_IMAGE_HEIGHT   = 2'd1;
  localparam logic [1:0] CFG_EDGE_THRESHOLD = 2'd2;

  localparam logic [PIX_W-1:0] EDGE_ON  = 8'd255;
  localparam logic [PIX_W-1:0] EDGE_OFF = 8'd0;

  // 3x3 window, entry row*3+col; row 0 is the oldest line, col 0 the oldest column
  typedef logic [8:0][PIX_W-1:0] win_t;
  // three row or column picks of 0..2, entry 1 is the centre
  typedef logic [2:0][1:0] sel_t;

  function automatic logic [PIX_W-1:0] pix_at(win_t w, logic [1:0] row, logic [1:0] col);
    logic [3:0] idx;
    idx = {2'b00, row} * 4'd3 + {2'b00, col};
    return w[idx];
  endfunction

  // OR of clamped centre-minus-neighbour differences, compared to the threshold
  function automatic logic edge_hit(win_t w, sel_t rs, sel_t cs, logic [PIX_W-1:0] thr);
    logic [PIX_W-1:0] ctr;
    logic [PIX_W-1:0] nb;
    logic [PIX_W-1:0] acc;
    acc = '0;
    ctr = pix_at(w, rs[1], cs[1]);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        if (!(i == 1 && j == 1)) begin
          nb = pix_at(w, rs[i], cs[j]);
          if (ctr > nb) begin
            acc = acc | (ctr - nb);
          end
        end
      end
    end
    return acc > thr;
  endfunction

endpackage

/* rtl/ndem_line_store.sv */
// Two-line pixel store: one read and one write port, registered read data.
module ndem_line_store (
  input  logic                          clk,
  input  logic                          rd_en,
  input  logic [ndem_pkg::COL_W-1:0]    rd_addr,
  output logic [ndem_pkg::LINE_DW-1:0]  rd_data,
  input  logic                          wr_en,
  input  logic [ndem_pkg::COL_W-1:0]    wr_addr,
  input  logic [ndem_pkg::LINE_DW-1:0]  wr_data
);
  import ndem_pkg::*;

  logic [LINE_DW-1:0] mem [0:MAX_WIDTH-1];
  logic [LINE_DW-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // hold read data until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/neighbour_difference_edge_map_unit.sv */
// Streaming 3x3 edge map: pixels enter in raster order at up to one per clock. Each
// pixel reads its column of the two-line store on transfer and writes it back when it
// moves on from stage 1, never in its own transfer cycle, so the store never sees a read
// and a write to the same column together. A pixel in the first row or the first column
// causes no result, most others cause one, the right column causes two and the last row up
// to four; results leave one per clock while the output is taken, so such pixels hold the
// input back. A result is registered in stage 1, stage 2 and the output register. The
// whole frame of results is delayed by one row and one column.
module neighbour_difference_edge_map_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_write_en,
  input  logic [1:0]                    cfg_index,
  input  logic [ndem_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ndem_pkg::PIX_W-1:0]    in_pixel,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ndem_pkg::PIX_W-1:0]    out_edge_value,
  output logic [ndem_pkg::ROW_W-1:0]    out_row,
  output logic [ndem_pkg::COL_W-1:0]    out_column,
  output logic                          out_last_of_run,
  output logic                          out_end_of_frame
);
  import ndem_pkg::*;

  // configuration
  logic [CFG_W-1:0] width_r, height_r;
  logic [PIX_W-1:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 12'd640;
      height_r <= 12'd480;
      thresh_r <= '0;
    end else if (cfg_write_en) begin
      case (cfg_index)
        CFG_IMAGE_WIDTH:    width_r  <= cfg_data;
        CFG_IMAGE_HEIGHT:   height_r <= cfg_data;
        CFG_EDGE_THRESHOLD: thresh_r <= cfg_data[PIX_W-1:0];
        default: ;
      endcase
    end
  end

  logic [CFG_W-1:0] w_eff, h_eff;
  always_comb begin
    w_eff = width_r;
    if (width_r < 12'd2) w_eff = 12'd2;
    else if (width_r > 12'(MAX_WIDTH)) w_eff = 12'(MAX_WIDTH);
    h_eff = height_r;
    if (height_r < 12'd2) h_eff = 12'd2;
  end

  // position of the next input
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic             last_col, last_row, in_xfer;

  assign last_col = {1'b0, col_r} >= (w_eff - 12'd1);
  assign last_row = row_r >= (h_eff - 12'd1);

  // stage 1: waits for line store data
  logic             s1_valid_r;
  logic [PIX_W-1:0] s1_pixel_r;
  logic [ROW_W-1:0] s1_row_r;
  logic [COL_W-1:0] s1_col_r;
  logic             s1_last_col_r, s1_last_row_r;
  logic             s1_go;

  // stage 2: window snapshot and pending results
  win_t             win_r, win_nxt, s2_win_r;
  logic [ROW_W-1:0] s2_row_r;
  logic [COL_W-1:0] s2_col_r;
  logic             s2_top_r, s2_left_r;
  logic [3:0]       s2_mask_r, mask_rest, s2_mask_nxt;
  logic             s2_can_load, s2_emit, out_take;

  // output register
  logic             out_valid_r;
  logic [PIX_W-1:0] out_edge_r;
  logic [ROW_W-1:0] out_row_r;
  logic [COL_W-1:0] out_col_r;
  logic             out_last_r, out_eof_r;

  logic [LINE_DW-1:0] line_rd;

  assign out_take    = !out_valid_r || out_ready;
  assign mask_rest   = s2_mask_r & (s2_mask_r - 4'd1);
  assign s2_emit     = (s2_mask_r != 4'd0) && out_take;
  assign s2_can_load = (s2_mask_r == 4'd0) || ((mask_rest == 4'd0) && out_take);
  assign s1_go       = s1_valid_r && s2_can_load;
  assign in_ready    = !s1_valid_r || s2_can_load;
  assign in_xfer     = in_valid && in_ready;

  ndem_line_store u_lines (
    .clk     (clk),
    .rd_en   (in_xfer),
    .rd_addr (col_r),
    .rd_data (line_rd),
    .wr_en   (s1_go),
    .wr_addr (s1_col_r),
    .wr_data ({line_rd[PIX_W-1:0], s1_pixel_r})
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (last_col) begin
          col_r <= '0;
          row_r <= last_row ? '0 : row_r + 1'b1;
        end else begin
          col_r <= col_r + 1'b1;
        end
        s1_valid_r <= 1'b1;
      end else if (s1_go) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_pixel_r    <= in_pixel;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_last_col_r <= last_col;
      s1_last_row_r <= last_row;
    end
  end

  // shift window left; new right column is {upper, middle, current}
  always_comb begin
    win_nxt = win_r;
    for (int k = 0; k < 3; k++) begin
      win_nxt[k*3]     = win_r[k*3+1];
      win_nxt[k*3 + 1] = win_r[k*3+2];
    end
    win_nxt[2] = line_rd[LINE_DW-1:PIX_W];
    win_nxt[5] = line_rd[PIX_W-1:0];
    win_nxt[8] = s1_pixel_r;
  end

  always_comb begin
    s2_mask_nxt = '0;
    if (s1_row_r != '0) begin
      s2_mask_nxt[0] = s1_col_r != '0;
      s2_mask_nxt[1] = s1_last_col_r;
      s2_mask_nxt[2] = s1_last_row_r && (s1_col_r != '0);
      s2_mask_nxt[3] = s1_last_row_r && s1_last_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r     <= '0;
      s2_mask_r <= '0;
    end else begin
      if (s1_go) begin
        win_r     <= win_nxt;
        s2_mask_r <= s2_mask_nxt;
      end else if (s2_emit) begin
        s2_mask_r <= mask_rest;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      s2_win_r  <= win_nxt;
      s2_row_r  <= s1_row_r;
      s2_col_r  <= s1_col_r;
      s2_top_r  <= s1_row_r == ROW_W'(1);
      s2_left_r <= s1_col_r == COL_W'(1);
    end
  end

  // pick the lowest pending result and its reflected window taps
  logic             k_low_row, k_right, k_eof;
  sel_t             rs, cs;
  logic [ROW_W-1:0] res_row;
  logic [COL_W-1:0] res_col;
  logic             res_hit;

  always_comb begin
    k_low_row = 1'b0;
    k_right   = 1'b0;
    k_eof     = 1'b0;
    if (s2_mask_r[0]) begin
      k_low_row = 1'b0;
      k_right   = 1'b0;
    end else if (s2_mask_r[1]) begin
      k_low_row = 1'b0;
      k_right   = 1'b1;
    end else if (s2_mask_r[2]) begin
      k_low_row = 1'b1;
      k_right   = 1'b0;
    end else begin
      k_low_row = 1'b1;
      k_right   = 1'b1;
      k_eof     = 1'b1;
    end
    if (k_low_row) begin
      rs[0] = 2'd1; rs[1] = 2'd2; rs[2] = 2'd1;
    end else begin
      rs[0] = s2_top_r ? 2'd2 : 2'd0; rs[1] = 2'd1; rs[2] = 2'd2;
    end
    if (k_right) begin
      cs[0] = 2'd1; cs[1] = 2'd2; cs[2] = 2'd1;
    end else begin
      cs[0] = s2_left_r ? 2'd2 : 2'd0; cs[1] = 2'd1; cs[2] = 2'd2;
    end
    res_row = k_low_row ? s2_row_r : s2_row_r - 1'b1;
    res_col = k_right ? s2_col_r : s2_col_r - 1'b1;
    res_hit = edge_hit(s2_win_r, rs, cs, thresh_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_emit) begin
      out_edge_r <= res_hit ? EDGE_ON : EDGE_OFF;
      out_row_r  <= res_row;
      out_col_r  <= res_col;
      out_last_r <= mask_rest == 4'd0;
      out_eof_r  <= k_eof;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_edge_value   = out_edge_r;
  assign out_row          = out_row_r;
  assign out_column       = out_col_r;
  assign out_last_of_run  = out_last_r;
  assign out_end_of_frame = out_eof_r;

  a_no_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && s1_go) |-> (col_r != s1_col_r))
    else $error("line store read and write hit the same column");

  a_eof_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_eof_r) |-> out_last_r)
    else $error("end of frame result not last of its run");

  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_col_r) && $stable(s1_pixel_r)))
    else $error("stalled pixel lost its slot");

  a_no_accept_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s2_can_load) |-> !in_ready)
    else $error("input taken while stage 1 is blocked");

endmodule
